// File: rtl/spq_pkg.sv
// Package for the stable priority queue: sizes, codes, payload and cell types.
// Used by spq_cell and stable_priority_queue; depends on nothing else.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int TAG_BITS = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_REMOVE    = 2'd1,
    REQ_LIST_ALL  = 2'd2,
    REQ_LIST_PRIO = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_UNDER   = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_NOMATCH = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  typedef logic [TAG_BITS-1:0] tag_t;

  typedef struct packed {
    logic [7:0] prio;
    tag_t       tag;
  } entry_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    cell_op_e op;
    entry_t   new_entry;
  } cell_ctrl_t;

  typedef struct packed {
    req_e        req_type;
    logic [7:0]  priority_req;
    logic [31:0] tag;
  } in_data_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  out_priority;
    logic [31:0] out_tag;
    logic        last;
  } out_data_t;

  // Request tag into stored width (truncate or zero-extend)
  function automatic tag_t tag_in(logic [31:0] t);
    tag_t r;
    r = '0;
    for (int b = 0; b < TAG_BITS && b < 32; b++) begin
      r[b] = t[b];
    end
    return r;
  endfunction

  // Stored tag back to the 32-bit result field
  function automatic logic [31:0] tag_out(tag_t t);
    logic [31:0] r;
    r = '0;
    for (int b = 0; b < TAG_BITS && b < 32; b++) begin
      r[b] = t[b];
    end
    return r;
  endfunction

endpackage

// File: rtl/spq_cell.sv
// One slot of the sorted row: holds an entry and shifts, inserts or rotates.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,         // slot lies below the fill count
  input  logic       tail_i,        // slot is the last occupied one
  input  logic       prev_after_i,  // new entry goes after the left neighbor
  input  entry_t     prev_i,
  input  entry_t     next_i,
  input  entry_t     head_i,
  output logic       after_o,       // new entry goes after this slot
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // Equal priorities keep arrival order: new goes after them
  assign after_o = occ_i && (entry_q.prio <= ctrl_i.new_entry.prio);
  assign entry_o = entry_q;

  // Next slot contents
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (after_o) begin
          entry_d = entry_q;
        end else if (prev_after_i) begin
          entry_d = ctrl_i.new_entry;
        end else begin
          entry_d = prev_i;
        end
      end
      OP_REMOVE: entry_d = next_i;
      OP_ROTATE: entry_d = tail_i ? head_i : next_i;
      default:   entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// File: rtl/stable_priority_queue.sv
// Stable priority queue: top level with request sequencer and output register.
// Depends on spq_pkg and spq_cell.
//
// Usage: requests come in on in_valid_i/in_ready_o/in_data_i, results leave
// on out_valid_o/out_ready_i/out_data_o, both valid/ready transactions.
// Entries sit in a row of CAPACITY cells kept in ascending priority order.
// Insert and remove finish in the cycle they are accepted; their single
// result is registered and visible in the next cycle. A list request walks
// the occupied cells by rotating the row one slot per cycle while the walk
// is not paused; the row is back in order when it ends. Each listed entry
// is held until the next match so that the final one can carry last.
// A new request is taken only when no list is running and the output
// register is empty or being drained in the same cycle, so a stalled
// receiver holds off the input side. When a matching entry is found while
// an earlier one is held and the output is full, the walk pauses until the
// result is taken. Reset empties the queue (fill count to zero) and clears
// output valid; slot contents are not cleared and are never read unwritten.
module stable_priority_queue import spq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_data_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_data_t out_data_o
);

  state_e     state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic       all_q, all_d;
  logic [7:0] match_q, match_d;
  logic       pend_valid_q, pend_valid_d;
  entry_t     pend_q, pend_d;
  logic       out_valid_q, out_valid_d;
  out_data_t  out_q, out_d;

  cell_ctrl_t ctrl;
  entry_t     cell_entry [CAPACITY];
  logic       cell_after [CAPACITY];
  entry_t     head;
  logic       slot_free;
  logic       accept;
  logic       push;
  out_data_t  push_data;
  logic       hit;

  assign head        = cell_entry[0];
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && slot_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign hit         = all_q || (head.prio == match_q);

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ, tail, prev_after;
    entry_t prev, next;

    assign occ  = count_q > CNT_W'(i);
    assign tail = count_q == CNT_W'(i + 1);

    if (i == 0) begin : g_first
      assign prev_after = 1'b1;
      assign prev       = ctrl.new_entry;
    end else begin : g_mid
      assign prev_after = cell_after[i-1];
      assign prev       = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next = cell_entry[i];
    end else begin : g_inner
      assign next = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ),
      .tail_i       (tail),
      .prev_after_i (prev_after),
      .prev_i       (prev),
      .next_i       (next),
      .head_i       (head),
      .after_o      (cell_after[i]),
      .entry_o      (cell_entry[i])
    );
  end

  // Sequencer: next state, cell command and result to push
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    scan_d         = scan_q;
    all_d          = all_q;
    match_d        = match_q;
    pend_valid_d   = pend_valid_q;
    pend_d         = pend_q;
    ctrl.op        = OP_HOLD;
    ctrl.new_entry = '{prio: in_data_i.priority_req, tag: tag_in(in_data_i.tag)};
    push           = 1'b0;
    push_data      = '{status: ST_OK, out_priority: 8'd0, out_tag: 32'd0, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.req_type)
            REQ_INSERT: begin
              push = 1'b1;
              if (count_q == CNT_W'(CAPACITY)) begin
                push_data.status = ST_FULL;
              end else begin
                ctrl.op = OP_INSERT;
                count_d = count_q + CNT_W'(1);
              end
            end
            REQ_REMOVE: begin
              push = 1'b1;
              if (count_q == '0) begin
                push_data.status = ST_UNDER;
              end else begin
                ctrl.op                = OP_REMOVE;
                count_d                = count_q - CNT_W'(1);
                push_data.out_priority = head.prio;
                push_data.out_tag      = tag_out(head.tag);
              end
            end
            default: begin
              state_d      = S_SCAN;
              scan_d       = '0;
              pend_valid_d = 1'b0;
              all_d        = (in_data_i.req_type == REQ_LIST_ALL);
              match_d      = in_data_i.priority_req;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_q == count_q) begin
          // Walk done: flush held entry with last, or report nothing found
          if (slot_free) begin
            push    = 1'b1;
            state_d = S_IDLE;
            if (pend_valid_q) begin
              push_data.out_priority = pend_q.prio;
              push_data.out_tag      = tag_out(pend_q.tag);
            end else begin
              push_data.status = all_q ? ST_EMPTY : ST_NOMATCH;
            end
          end
        end else if (!hit) begin
          ctrl.op = OP_ROTATE;
          scan_d  = scan_q + CNT_W'(1);
        end else if (!pend_valid_q) begin
          ctrl.op      = OP_ROTATE;
          scan_d       = scan_q + CNT_W'(1);
          pend_valid_d = 1'b1;
          pend_d       = head;
        end else if (slot_free) begin
          // Earlier hit is not the final one
          ctrl.op                = OP_ROTATE;
          scan_d                 = scan_q + CNT_W'(1);
          pend_d                 = head;
          push                   = 1'b1;
          push_data.out_priority = pend_q.prio;
          push_data.out_tag      = tag_out(pend_q.tag);
          push_data.last         = 1'b0;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      scan_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    all_q   <= all_d;
    match_q <= match_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

endmodule
